// ===== hw/rtl/hkst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hkst_pkg: shared types and constants for the held key slot tracker
// Word layouts, operation and status codes, sequencer states and the
// slot table control group.
// ----------------------------------------------------------------------------
package hkst_pkg;

  localparam int unsigned KEY_W = 16;
  localparam logic [KEY_W-1:0] FORCED_SLOT = 16'hFFFF;

  localparam logic [1:0] OP_PRESS         = 2'd0;
  localparam logic [1:0] OP_RELEASE       = 2'd1;
  localparam logic [1:0] OP_RESET_TRIG    = 2'd2;
  localparam logic [1:0] OP_RESET_STATE   = 2'd3;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_HELD      = 2'd1;
  localparam logic [1:0] STATUS_NO_FREE   = 2'd2;
  localparam logic [1:0] STATUS_NOT_HELD  = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key_code;
  } in_word_t;

  typedef struct packed {
    logic       changed;
    logic       button_down;
    logic       went_down_flag;
    logic       went_up_flag;
    logic [1:0] status;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic clear_all;
    logic wr_en;
  } slot_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hkst_slot_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hkst_slot_table: key slot storage
// Holds one key code per slot, with one read port, one write port and a
// clear of the whole table. A write in the same cycle as a clear wins.
// ----------------------------------------------------------------------------
module hkst_slot_table #(
  parameter int unsigned SLOT_COUNT = 4,
  parameter int unsigned IDX_W      = 2
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  hkst_pkg::slot_ctl_t    ctl,
  input  wire  [IDX_W-1:0]             wr_idx,
  input  wire  [hkst_pkg::KEY_W-1:0]   wr_data,
  input  wire  [IDX_W-1:0]             rd_idx,
  output logic [hkst_pkg::KEY_W-1:0]   rd_data
);
  import hkst_pkg::*;

  logic [KEY_W-1:0] slot_r [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (ctl.wr_en && (wr_idx == IDX_W'(i))) begin
          slot_r[i] <= wr_data;
        end else if (ctl.clear_all) begin
          slot_r[i] <= '0;
        end
      end
    end
  end

  assign rd_data = slot_r[rd_idx];

endmodule

`default_nettype wire

// ===== hw/rtl/held_key_slot_tracker_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// held_key_slot_tracker_top: held key slot tracker
// Tracks the keys that hold one button in a small slot table, with sticky
// went-down and went-up flags and a release lock register.
// ----------------------------------------------------------------------------
// A press or release of a nonzero key scans the slots through the single read
// port, one slot per cycle, in ST_SCAN; the result is then registered in
// ST_FINISH, which holds while the output register is full and not taken.
// Every other word goes from ST_IDLE straight to ST_FINISH with no scan.
// A new word is accepted once the previous result is placed in the output
// register. Reset frees all slots and clears the flags and the release lock.
module held_key_slot_tracker_top #(
  parameter int unsigned SLOT_COUNT = 4,
  parameter int unsigned KEY_BITS   = 15
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire hkst_pkg::in_word_t in_word,
  output logic                 out_valid,
  input  wire                  out_ready,
  output hkst_pkg::out_word_t  out_word,
  input  wire                  cfg_wr_en,
  input  wire                  cfg_wr_data
);
  import hkst_pkg::*;

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((32'd1 << KEY_BITS) - 32'd1);

  seq_state_t       state_r, state_nxt;
  logic [1:0]       op_r;
  logic [KEY_W-1:0] key_r;
  logic             key_zero_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             hit_found_r, hit_found_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             held_one_r, held_one_nxt;
  logic             held_two_r, held_two_nxt;
  logic             down_r, down_nxt;
  logic             went_down_r, went_down_nxt;
  logic             went_up_r, went_up_nxt;
  logic             release_lock_r;
  logic             out_valid_r;
  out_word_t        out_word_r, out_word_nxt;

  logic             accept;
  logic             scan_active;
  logic             commit;
  logic             scan_last;
  logic [KEY_W-1:0] key_masked;
  logic [KEY_W-1:0] rd_data;
  logic             slot_free;
  logic             slot_hit;
  slot_ctl_t        slot_ctl;
  logic [IDX_W-1:0] wr_idx;
  logic [KEY_W-1:0] wr_data;

  hkst_slot_table #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_slot_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (slot_ctl),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_idx  (idx_r),
    .rd_data (rd_data)
  );

  assign key_masked = in_word.key_code & KEY_MASK;
  assign scan_last  = (idx_r == LAST_IDX);
  assign slot_free  = (rd_data == '0);
  assign slot_hit   = (rd_data == key_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if ((key_masked != '0) &&
              ((in_word.op == OP_PRESS) || (in_word.op == OP_RELEASE))) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    scan_active = 1'b0;
    commit      = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready    = 1'b1;
      ST_SCAN:   scan_active = 1'b1;
      ST_FINISH: commit      = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    idx_nxt        = idx_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    held_one_nxt   = held_one_r;
    held_two_nxt   = held_two_r;
    if (accept) begin
      idx_nxt        = '0;
      hit_found_nxt  = 1'b0;
      hit_idx_nxt    = '0;
      free_found_nxt = 1'b0;
      free_idx_nxt   = '0;
      held_one_nxt   = 1'b0;
      held_two_nxt   = 1'b0;
    end else if (scan_active) begin
      idx_nxt = idx_r + IDX_W'(1);
      if (slot_hit && !hit_found_r) begin
        hit_found_nxt = 1'b1;
        hit_idx_nxt   = idx_r;
      end
      if (slot_free && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = idx_r;
      end
      if (!slot_free) begin
        held_one_nxt = 1'b1;
        held_two_nxt = held_two_r || held_one_r;
      end
    end
  end

  always_comb begin
    down_nxt      = down_r;
    went_down_nxt = went_down_r;
    went_up_nxt   = went_up_r;
    slot_ctl      = '0;
    wr_idx        = '0;
    wr_data       = '0;
    out_word_nxt  = '0;
    out_word_nxt.status = STATUS_DONE;
    case (op_r)
      OP_PRESS: begin
        if (key_zero_r) begin
          slot_ctl.clear_all = 1'b1;
          slot_ctl.wr_en     = 1'b1;
          wr_idx             = '0;
          wr_data            = FORCED_SLOT;
          down_nxt           = 1'b1;
          went_down_nxt      = 1'b1;
          out_word_nxt.changed = !down_r;
        end else if (hit_found_r) begin
          out_word_nxt.status = STATUS_HELD;
        end else if (!free_found_r) begin
          out_word_nxt.status = STATUS_NO_FREE;
        end else begin
          slot_ctl.wr_en = 1'b1;
          wr_idx         = free_idx_r;
          wr_data        = key_r;
          down_nxt       = 1'b1;
          went_down_nxt  = 1'b1;
          out_word_nxt.changed = !down_r;
        end
      end
      OP_RELEASE: begin
        if (key_zero_r) begin
          slot_ctl.clear_all = 1'b1;
          down_nxt           = 1'b0;
          went_up_nxt        = 1'b1;
          out_word_nxt.changed = down_r;
        end else if (!hit_found_r) begin
          out_word_nxt.status = STATUS_NOT_HELD;
        end else begin
          slot_ctl.wr_en = 1'b1;
          wr_idx         = hit_idx_r;
          wr_data        = '0;
          went_up_nxt    = 1'b1;
          down_nxt       = held_two_r ? down_r : 1'b0;
          out_word_nxt.changed = down_r && !down_nxt;
        end
      end
      OP_RESET_TRIG: begin
        went_down_nxt = 1'b0;
        went_up_nxt   = 1'b0;
      end
      OP_RESET_STATE: begin
        if (!release_lock_r) begin
          slot_ctl.clear_all = 1'b1;
          down_nxt           = 1'b0;
          out_word_nxt.changed = down_r;
        end
        went_down_nxt = 1'b0;
        went_up_nxt   = 1'b0;
      end
      default: ;
    endcase
    out_word_nxt.button_down    = down_nxt;
    out_word_nxt.went_down_flag = went_down_nxt;
    out_word_nxt.went_up_flag   = went_up_nxt;
    if (!commit) begin
      slot_ctl = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      down_r         <= 1'b0;
      went_down_r    <= 1'b0;
      went_up_r      <= 1'b0;
      release_lock_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        release_lock_r <= cfg_wr_data;
      end
      if (commit) begin
        down_r      <= down_nxt;
        went_down_r <= went_down_nxt;
        went_up_r   <= went_up_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_word.op;
      key_r      <= key_masked;
      key_zero_r <= (key_masked == '0);
    end
    idx_r        <= idx_nxt;
    hit_found_r  <= hit_found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    held_one_r   <= held_one_nxt;
    held_two_r   <= held_two_nxt;
    if (commit) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire
